### rtl/fats_pkg.sv
package fats_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned SigWidth  = 25;  // hidden + fraction + guard
   localparam int unsigned MagWidth  = 26;  // one carry bit
   localparam int unsigned LzWidth   = 5;
   localparam int unsigned AlignMax  = 25;

   localparam logic OpAdd = 1'b0;
   localparam logic OpSub = 1'b1;

   // aligned operands, larger exponent known
   typedef struct packed {
      logic                 valid;
      logic                 sign_a;
      logic                 sign_b;
      logic [SigWidth-1:0]  sig_a;
      logic [SigWidth-1:0]  sig_b;
      logic [ExpWidth:0]    exp;
   } align_type;

   // raw magnitude
   typedef struct packed {
      logic                 valid;
      logic                 sign;
      logic [MagWidth-1:0]  mag;
      logic [ExpWidth:0]    exp;
   } mag_type;

endpackage

### rtl/fats_align.sv
module fats_align (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  logic                    opcode,
   input  logic [31:0]             operand_a,
   input  logic [31:0]             operand_b,
   output fats_pkg::align_type     stage_ff
);

   fats_pkg::align_type stage_in;
   logic [7:0]  ea, eb, shift_amt;
   logic [fats_pkg::SigWidth-1:0] ma, mb, small_sig;
   logic a_big;

   always_comb begin
      ea = operand_a[30:23];
      eb = operand_b[30:23];
      ma = {1'b1, operand_a[22:0], 1'b0};
      mb = {1'b1, operand_b[22:0], 1'b0};
      a_big = ea > eb;
      shift_amt = a_big ? ea - eb : eb - ea;
      small_sig = a_big ? mb : ma;
      if (shift_amt >= 8'(fats_pkg::AlignMax)) begin
         small_sig = '0;
      end else begin
         small_sig = small_sig >> shift_amt[4:0];
      end
      stage_in.valid  = in_valid;
      stage_in.sign_a = operand_a[31];
      stage_in.sign_b = operand_b[31] ^ (opcode == fats_pkg::OpSub);
      stage_in.sig_a  = a_big ? ma : small_sig;
      stage_in.sig_b  = a_big ? small_sig : mb;
      stage_in.exp    = {1'b0, a_big ? ea : eb};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### rtl/fats_addsub.sv
module fats_addsub (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  fats_pkg::align_type  in_stage,
   output fats_pkg::mag_type    stage_ff
);

   fats_pkg::mag_type stage_in;

   always_comb begin
      stage_in.valid = in_stage.valid;
      stage_in.exp   = in_stage.exp;
      if (in_stage.sign_a != in_stage.sign_b) begin
         if (in_stage.sig_a > in_stage.sig_b) begin
            stage_in.mag  = {1'b0, in_stage.sig_a - in_stage.sig_b};
            stage_in.sign = in_stage.sign_a;
         end else begin
            stage_in.mag  = {1'b0, in_stage.sig_b - in_stage.sig_a};
            stage_in.sign = in_stage.sign_b;
         end
      end else begin
         stage_in.mag  = {1'b0, in_stage.sig_a} + {1'b0, in_stage.sig_b};
         stage_in.sign = in_stage.sign_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### rtl/fats_norm.sv
module fats_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  fats_pkg::mag_type  in_stage,
   output logic               valid_ff,
   output logic [31:0]        word_ff
);

   logic [fats_pkg::LzWidth-1:0] lz;
   logic [fats_pkg::MagWidth-1:0] norm;
   logic [7:0] exp_out;
   logic [31:0] word_in;
   logic found;

   // mag < 2^26, exp field stored as exponent; result exp = exp - 1 + adjust
   always_comb begin
      lz = '0;
      found = 1'b0;
      for (int i = fats_pkg::MagWidth - 1; i >= 0; i--) begin
         if (!found && in_stage.mag[i]) begin
            found = 1'b1;
            lz = fats_pkg::LzWidth'(fats_pkg::MagWidth - 1 - i);
         end
      end
      if (in_stage.mag[25]) begin
         norm    = in_stage.mag >> 2;
         exp_out = in_stage.exp[7:0] + 8'd1;
      end else if (in_stage.mag[24]) begin
         norm    = in_stage.mag >> 1;
         exp_out = in_stage.exp[7:0];
      end else begin
         norm    = in_stage.mag << (lz - 5'd2);
         exp_out = in_stage.exp[7:0] - 8'd1 - 8'(lz - 5'd2);
      end
      if (!found) begin
         word_in = '0;
      end else begin
         word_in = {in_stage.sign, exp_out, norm[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

endmodule

### rtl/float32_add_subtract_truncating_unit.sv
// Truncating single-precision add/subtract. Three register stages (align,
// magnitude add/subtract, normalise and pack); one word accepted per cycle
// while req_stall is low. A stall on rsp holds the whole pipeline, but
// empty stages fill while the output waits. No rounding or special values.
module float32_add_subtract_truncating_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sum_word
);

   fats_pkg::align_type s1;
   fats_pkg::mag_type   s2;
   logic adv3, adv2, adv1;

   assign adv3 = !rsp_valid || !rsp_stall;
   assign adv2 = adv3 || !s2.valid;
   assign adv1 = adv2 || !s1.valid;
   assign req_stall = !adv1;

   fats_align u_align (
      .clock(clock), .reset(reset), .advance(adv1), .in_valid(req_valid),
      .opcode(req_opcode), .operand_a(req_operand_a), .operand_b(req_operand_b),
      .stage_ff(s1)
   );

   fats_addsub u_addsub (
      .clock(clock), .reset(reset), .advance(adv2), .in_stage(s1), .stage_ff(s2)
   );

   fats_norm u_norm (
      .clock(clock), .reset(reset), .advance(adv3), .in_stage(s2),
      .valid_ff(rsp_valid), .word_ff(rsp_sum_word)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sum_word))
      else $error("output lost under stall");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1.valid && s2.valid && rsp_valid)
      else $error("stall with bubble");
   a_move: assert property (@(posedge clock) disable iff (reset)
      s2.valid && !rsp_stall |=> rsp_valid)
      else $error("word dropped");

endmodule

### tb/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandWords = 850;
   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned Latency = 3;

   typedef struct {
      logic        opcode;
      logic [31:0] a;
      logic [31:0] b;
      logic        known;
      logic [31:0] sum;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_sum_word;

   logic [31:0] expected_sums[$];
   int unsigned mismatches;
   int unsigned checked;
   int unsigned cycles;
   bit          hold_rsp;
   bit          rsp_quiet;

   float32_add_subtract_truncating_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sum_word  (rsp_sum_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] fp_add_trunc(logic opcode, logic [31:0] a, logic [31:0] b);
      logic          sa, sb, sgn;
      logic [7:0]    ea, eb;
      logic [25:0]   ma, mb, mag;
      int            ex;
      int unsigned   shift_amt;
      sa = a[31];
      sb = b[31] ^ (opcode == fats_pkg::OpSub);
      ea = a[30:23];
      eb = b[30:23];
      ma = {2'b01, a[22:0], 1'b0};
      mb = {2'b01, b[22:0], 1'b0};
      if (ea > eb) begin
         shift_amt = 32'(ea - eb);
         mb = (shift_amt >= fats_pkg::AlignMax) ? '0 : mb >> shift_amt;
         ex = int'(ea) - 1;
      end else begin
         shift_amt = 32'(eb - ea);
         ma = (shift_amt >= fats_pkg::AlignMax) ? '0 : ma >> shift_amt;
         ex = int'(eb) - 1;
      end
      if (sa != sb) begin
         if (ma > mb) begin
            mag = ma - mb;
            sgn = sa;
         end else begin
            mag = mb - ma;
            sgn = sb;
         end
      end else begin
         mag = ma + mb;
         sgn = sa;
      end
      if (mag == 0) return 32'h0;
      while (mag >= 26'h1000000) begin
         mag = mag >> 1;
         ex++;
      end
      while (mag < 26'h0800000) begin
         mag = mag << 1;
         ex--;
      end
      return {sgn, ex[7:0], mag[22:0]};
   endfunction

   function automatic logic [31:0] rand_float();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 5))
         0: w[30:23] = 8'($urandom_range(120, 134));
         1: w[30:23] = 8'($urandom_range(0, 3));
         2: w[30:23] = 8'($urandom_range(252, 255));
         default: ;
      endcase
      return w;
   endfunction

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word %08h", rsp_sum_word);
            end else begin
               logic [31:0] exp_sum;
               exp_sum = expected_sums.pop_front();
               checked++;
               if (rsp_sum_word !== exp_sum) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sum_word: expected %08h got %08h", exp_sum, rsp_sum_word);
               end
            end
         end
         rsp_stall <= hold_rsp || (!rsp_quiet && $urandom_range(0, 99) < 30);
      end
   end

   task automatic send_word(logic opcode, logic [31:0] a, logic [31:0] b, logic known,
                            logic [31:0] sum, bit idle_ok);
      logic [31:0] pred;
      while (idle_ok && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      pred = fp_add_trunc(opcode, a, b);
      if (known && pred !== sum) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row %08h %08h: listed %08h predicted %08h", a, b, sum, pred);
      end
      req_valid     <= 1'b1;
      req_opcode    <= opcode;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      expected_sums.push_back(known ? sum : pred);
   endtask

   stim_row_type directed[] = '{
      '{fats_pkg::OpAdd, 32'h3f800000, 32'h3f800000, 1'b1, 32'h40000000},
      '{fats_pkg::OpSub, 32'h3f800000, 32'h3f800000, 1'b1, 32'h00000000},
      '{fats_pkg::OpAdd, 32'h3f800000, 32'hbf800000, 1'b1, 32'h00000000},
      '{fats_pkg::OpSub, 32'h40000000, 32'h3f800000, 1'b1, 32'h3f800000},
      '{fats_pkg::OpSub, 32'h3f800000, 32'h40000000, 1'b1, 32'hbf800000},
      '{fats_pkg::OpAdd, 32'h00000000, 32'h00000000, 1'b1, 32'h00800000},
      '{fats_pkg::OpAdd, 32'h7f800000, 32'h7f800000, 1'b1, 32'h00000000},
      '{fats_pkg::OpAdd, 32'hffffffff, 32'hffffffff, 1'b0, 32'h0},
      '{fats_pkg::OpSub, 32'hffffffff, 32'h7fffffff, 1'b0, 32'h0},
      '{fats_pkg::OpAdd, 32'h4c000000, 32'h3f800000, 1'b0, 32'h0},
      '{fats_pkg::OpAdd, 32'h4c800000, 32'h3f800000, 1'b1, 32'h4c800000},
      '{fats_pkg::OpAdd, 32'h3f800000, 32'h4d000000, 1'b1, 32'h4d000000},
      '{fats_pkg::OpSub, 32'h3f800001, 32'h3f800000, 1'b0, 32'h0},
      '{fats_pkg::OpSub, 32'h3fffffff, 32'h3f800000, 1'b0, 32'h0},
      '{fats_pkg::OpAdd, 32'h80000000, 32'h00000000, 1'b0, 32'h0},
      '{fats_pkg::OpSub, 32'h807fffff, 32'h007fffff, 1'b0, 32'h0},
      '{fats_pkg::OpAdd, 32'h5a5a5a5a, 32'ha5a5a5a5, 1'b0, 32'h0},
      '{fats_pkg::OpSub, 32'h0000ffff, 32'hffff0000, 1'b0, 32'h0}
   };

   initial begin
      int unsigned n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = 1'b0;
      req_operand_a = '0;
      req_operand_b = '0;
      rsp_stall = 1'b0;
      hold_rsp = 1'b0;
      rsp_quiet = 1'b0;
      mismatches = 0;
      checked = 0;
      cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_word(directed[i].opcode, directed[i].a, directed[i].b,
                   directed[i].known, directed[i].sum, 1'b1);

      for (n = 0; n < RandWords; n++) begin
         rsp_quiet <= (n >= 300 && n < 450);
         if (n == 500) begin
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (60) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         send_word(1'($urandom_range(0, 1)), rand_float(), rand_float(), 1'b0, '0,
                   !(n >= 300 && n < 450) && !(n >= 500 && n < 540));
      end
      req_valid <= 1'b0;
      rsp_quiet <= 1'b0;

      while (expected_sums.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      $display("checked %0d sum words from directed table and random operand pairs,", checked);
      $display("with add and subtract, wide exponent spread, idle gaps and a long output stall");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
